// File: src/utf8_stream_decoder_core_macros.svh
// Assertion macros for the UTF-8 stream decoder.
// Included by the top level; no other dependencies.
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define UTF8SD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8sd: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define UTF8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8sd: next-cycle check failed");

`endif

// File: src/utf8sd_pkg.sv
// Shared types, codes and helper functions for the UTF-8 stream decoder.
// No dependencies; used by every module of the block.
package utf8sd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // error_kind codes
    typedef logic [1:0] err_kind_t;
    localparam err_kind_t ERR_NONE      = 2'd0;
    localparam err_kind_t ERR_TOO_SHORT = 2'd1;
    localparam err_kind_t ERR_INVALID   = 2'd2;
    localparam err_kind_t ERR_TRUNCATED = 2'd3;

    // sequence tracker: idle, 1..3 continuation bytes still due, error
    typedef enum logic [2:0] {
        SEQ_IDLE  = 3'd0,
        SEQ_NEED1 = 3'd1,
        SEQ_NEED2 = 3'd2,
        SEQ_NEED3 = 3'd3,
        SEQ_ERROR = 3'd4
    } seq_state_t;

    // leading-ones count of a byte, 0..8
    typedef logic [3:0] lead_cnt_t;

    // payload structs
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              stream_end;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        err_kind_t       error_kind;
        logic            last_of_run;
    } out_item_t;

    // result queue sizing
    localparam int unsigned MAX_RESULTS = 2;
    localparam int unsigned QUEUE_DEPTH = 3;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned PUSH_W      = $clog2(MAX_RESULTS + 1);

    // results of one byte, handed from the decode step to the queue
    typedef struct packed {
        logic [PUSH_W-1:0] count;
        out_item_t         first;
        out_item_t         second;
    } push_t;

    // full output of the decode step
    typedef struct packed {
        seq_state_t      state_next;
        logic [CP_W-1:0] partial_next;
        push_t           push;
    } step_out_t;

    // payload bits a lead byte keeps, by leading-ones count
    function automatic logic [BYTE_W-1:0] lead_bits_mask(input lead_cnt_t lead);
        logic [BYTE_W-1:0] m;
        unique case (lead)
            4'd0:    m = 8'hFF;
            4'd1:    m = 8'h3F;
            4'd2:    m = 8'h1F;
            4'd3:    m = 8'h0F;
            4'd4:    m = 8'h07;
            4'd5:    m = 8'h03;
            4'd6:    m = 8'h01;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // circular pointer increment over the queue depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + PTR_W'(1);
        end
        return n;
    endfunction

endpackage

// File: src/utf8_stream_decoder_core.sv
// Top level of the UTF-8 stream decoder: input register, decode step and
// result queue. Depends on utf8sd_pkg, utf8sd_step, utf8sd_res_fifo and the
// assertion macro header.
//
// Usage: the byte channel (byte_valid, byte_stall, byte_data) carries one
// byte per transaction, with stream_end set on the last byte of a stream.
// The code point channel (cp_valid, cp_stall, cp_data) carries decoded code
// points, U+FFFD with an error kind on malformed input; last_of_run marks
// the final result of each byte. A byte gives zero, one or two results.
// An accepted byte is registered, decoded, and its results written to the queue.
// Throughput: one byte per cycle while bytes give at most one result each and
// cp_stall is low; a byte with two results can hold the next byte back.
// When the receiver stalls, results collect in the three-entry queue; once
// two are waiting, a held byte raises byte_stall. No result is lost or reordered.
// Reset clears the tracker to idle with no partial code point and empties
// the queue; the first byte after reset or after stream_end starts a stream.
`include "utf8_stream_decoder_core_macros.svh"

module utf8_stream_decoder_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  utf8sd_pkg::in_item_t   byte_data,
    output logic                   cp_valid,
    input  logic                   cp_stall,
    output utf8sd_pkg::out_item_t  cp_data
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    utf8sd_pkg::in_item_t          in_item_reg;
    utf8sd_pkg::seq_state_t        state_reg;
    logic [utf8sd_pkg::CP_W-1:0]   partial_reg;
    utf8sd_pkg::step_out_t         step;
    logic                          room;
    logic                          advance;
    logic                          accept;

    // handshake
    assign advance       = in_valid_reg && room;
    assign byte_stall    = in_valid_reg && !room;
    assign accept        = byte_valid && !byte_stall;
    assign in_valid_next = accept || (in_valid_reg && !advance);

    // decode one byte against the tracker
    utf8sd_step u_step
    (
        .item    (in_item_reg),
        .state   (state_reg),
        .partial (partial_reg),
        .step    (step)
    );

    // result queue
    utf8sd_res_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (advance),
        .push       (step.push),
        .pop        (!cp_stall),
        .head_valid (cp_valid),
        .head       (cp_data),
        .room       (room)
    );

    // control and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= utf8sd_pkg::SEQ_IDLE;
            partial_reg  <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                state_reg   <= step.state_next;
                partial_reg <= step.partial_next;
            end
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= byte_data;
        end
    end

    // any error result carries the replacement character
    `UTF8SD_ASSERT_IMP(a_err_is_fffd, clk, rst_n,
        cp_valid && (cp_data.error_kind != utf8sd_pkg::ERR_NONE),
        cp_data.code_point == utf8sd_pkg::REPLACEMENT_CP)
    // no partial bits survive outside an open sequence
    `UTF8SD_ASSERT_IMP(a_partial_clear, clk, rst_n,
        state_reg == utf8sd_pkg::SEQ_IDLE || state_reg == utf8sd_pkg::SEQ_ERROR,
        partial_reg == '0)
    // a stream-end byte leaves the tracker idle
    `UTF8SD_ASSERT_NEXT(a_end_idle, clk, rst_n,
        advance && in_item_reg.stream_end,
        state_reg == utf8sd_pkg::SEQ_IDLE)

endmodule

// File: src/utf8sd_step.sv
// Combinational decode step: one byte plus tracker state in, next state and
// up to two results out. Depends on utf8sd_pkg.
module utf8sd_step
(
    input  utf8sd_pkg::in_item_t          item,
    input  utf8sd_pkg::seq_state_t        state,
    input  logic [utf8sd_pkg::CP_W-1:0]   partial,
    output utf8sd_pkg::step_out_t         step
);

    utf8sd_pkg::lead_cnt_t         lead;
    utf8sd_pkg::seq_state_t        st_eff;
    utf8sd_pkg::seq_state_t        st_new;
    logic                          too_short;
    logic                          tail_valid;
    logic [utf8sd_pkg::CP_W-1:0]   cp_base;
    logic [utf8sd_pkg::CP_W-1:0]   cp_shift;
    logic [utf8sd_pkg::CP_W-1:0]   cp_acc;
    utf8sd_pkg::out_item_t         res_a;
    utf8sd_pkg::out_item_t         res_b;

    // leading ones: the highest zero bit decides
    always_comb
    begin
        lead = 4'd8;
        for (int i = 0; i < utf8sd_pkg::BYTE_W; i++)
        begin
            if (!item.data_byte[i])
            begin
                lead = utf8sd_pkg::lead_cnt_t'(utf8sd_pkg::BYTE_W - 1 - i);
            end
        end
    end

    // unused state codes behave as the error state
    always_comb
    begin
        unique case (state)
            utf8sd_pkg::SEQ_IDLE,
            utf8sd_pkg::SEQ_NEED1,
            utf8sd_pkg::SEQ_NEED2,
            utf8sd_pkg::SEQ_NEED3: st_eff = state;
            default:               st_eff = utf8sd_pkg::SEQ_ERROR;
        endcase
    end

    // tracker transition
    always_comb
    begin
        unique case (lead)
            4'd0: st_new = utf8sd_pkg::SEQ_IDLE;
            4'd1:
            begin
                unique case (st_eff)
                    utf8sd_pkg::SEQ_NEED1: st_new = utf8sd_pkg::SEQ_IDLE;
                    utf8sd_pkg::SEQ_NEED2: st_new = utf8sd_pkg::SEQ_NEED1;
                    utf8sd_pkg::SEQ_NEED3: st_new = utf8sd_pkg::SEQ_NEED2;
                    default:               st_new = utf8sd_pkg::SEQ_ERROR;
                endcase
            end
            4'd2:    st_new = utf8sd_pkg::SEQ_NEED1;
            4'd3:    st_new = utf8sd_pkg::SEQ_NEED2;
            4'd4:    st_new = utf8sd_pkg::SEQ_NEED3;
            default: st_new = utf8sd_pkg::SEQ_ERROR;
        endcase
    end

    // code point accumulation; a cut-short sequence drops its bits
    assign too_short = (st_eff == utf8sd_pkg::SEQ_NEED1 ||
                        st_eff == utf8sd_pkg::SEQ_NEED2 ||
                        st_eff == utf8sd_pkg::SEQ_NEED3) && (lead != 4'd1);
    assign cp_base   = too_short ? '0 : partial;
    assign cp_shift  = (lead == 4'd1) ? {cp_base[utf8sd_pkg::CP_W-7:0], 6'b0} : cp_base;
    assign cp_acc    = cp_shift | utf8sd_pkg::CP_W'(item.data_byte &
                                                   utf8sd_pkg::lead_bits_mask(lead));

    // result list: optional too-short marker, then at most one tail result
    always_comb
    begin
        res_a.code_point  = utf8sd_pkg::REPLACEMENT_CP;
        res_a.error_kind  = utf8sd_pkg::ERR_TOO_SHORT;
        res_a.last_of_run = 1'b0;
        res_b.last_of_run = 1'b1;
        tail_valid        = 1'b1;
        if (st_new == utf8sd_pkg::SEQ_IDLE)
        begin
            res_b.code_point = cp_acc;
            res_b.error_kind = utf8sd_pkg::ERR_NONE;
        end
        else if (st_new == utf8sd_pkg::SEQ_ERROR)
        begin
            res_b.code_point = utf8sd_pkg::REPLACEMENT_CP;
            res_b.error_kind = utf8sd_pkg::ERR_INVALID;
        end
        else
        begin
            res_b.code_point = utf8sd_pkg::REPLACEMENT_CP;
            res_b.error_kind = utf8sd_pkg::ERR_TRUNCATED;
            tail_valid       = item.stream_end;
        end
        res_a.last_of_run = !tail_valid;
    end

    // pack outputs
    always_comb
    begin
        step.push.count  = utf8sd_pkg::PUSH_W'(too_short) +
                           utf8sd_pkg::PUSH_W'(tail_valid);
        step.push.first  = too_short ? res_a : res_b;
        step.push.second = res_b;
        if (item.stream_end)
        begin
            step.state_next   = utf8sd_pkg::SEQ_IDLE;
            step.partial_next = '0;
        end
        else if (st_new == utf8sd_pkg::SEQ_IDLE || st_new == utf8sd_pkg::SEQ_ERROR)
        begin
            step.state_next   = st_new;
            step.partial_next = '0;
        end
        else
        begin
            step.state_next   = st_new;
            step.partial_next = cp_acc;
        end
    end

endmodule

// File: src/utf8sd_res_fifo.sv
// Small result queue: takes up to two results per cycle, gives one per cycle while pop is set.
// Depends on utf8sd_pkg.
module utf8sd_res_fifo
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_en,
    input  utf8sd_pkg::push_t      push,
    input  logic                   pop,
    output logic                   head_valid,
    output utf8sd_pkg::out_item_t  head,
    output logic                   room
);

    utf8sd_pkg::out_item_t                 mem_reg [utf8sd_pkg::QUEUE_DEPTH];
    logic [utf8sd_pkg::PTR_W-1:0]          wr_ptr_reg;
    logic [utf8sd_pkg::PTR_W-1:0]          wr_ptr_next;
    logic [utf8sd_pkg::PTR_W-1:0]          wr_ptr_inc;
    logic [utf8sd_pkg::PTR_W-1:0]          rd_ptr_reg;
    logic [utf8sd_pkg::PTR_W-1:0]          rd_ptr_next;
    logic [utf8sd_pkg::CNT_W-1:0]          count_reg;
    logic [utf8sd_pkg::CNT_W-1:0]          count_next;
    logic [utf8sd_pkg::PUSH_W-1:0]         n_push;
    logic                                  pop_fire;

    // status
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign room       = (count_reg <=
                         utf8sd_pkg::CNT_W'(utf8sd_pkg::QUEUE_DEPTH - utf8sd_pkg::MAX_RESULTS));
    assign pop_fire   = pop && head_valid;
    assign n_push     = push_en ? push.count : '0;
    assign wr_ptr_inc = utf8sd_pkg::ptr_inc(wr_ptr_reg);

    // pointer and count update
    always_comb
    begin
        unique case (n_push)
            2'd0:    wr_ptr_next = wr_ptr_reg;
            2'd1:    wr_ptr_next = wr_ptr_inc;
            default: wr_ptr_next = utf8sd_pkg::ptr_inc(wr_ptr_inc);
        endcase
        rd_ptr_next = pop_fire ? utf8sd_pkg::ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + utf8sd_pkg::CNT_W'(n_push)
                      - utf8sd_pkg::CNT_W'(pop_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (n_push != '0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (n_push == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.second;
        end
    end

endmodule
